// ===== sv/scbp_pkg.sv =====
package scbp_pkg;

    // Pool geometry
    localparam int SMALL_SLOTS  = 64;
    localparam int MEDIUM_SLOTS = 32;
    localparam int LARGE_SLOTS  = 8;
    localparam int COUNT_BITS   = 16;
    localparam int TOTAL_SLOTS  = SMALL_SLOTS + MEDIUM_SLOTS + LARGE_SLOTS;

    localparam int SMALL_BASE  = 0;
    localparam int MEDIUM_BASE = SMALL_SLOTS;
    localparam int LARGE_BASE  = SMALL_SLOTS + MEDIUM_SLOTS;

    // Field widths
    localparam int MODE_W     = 2;
    localparam int LEN_W      = 11;
    localparam int SLOT_W     = 7;
    localparam int STATUS_W   = 3;
    localparam int CLASS_W    = 2;
    localparam int LIMIT_W    = 11;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 11;

    // Stack index and fill count widths
    localparam int SMALL_IDX_W  = (SMALL_SLOTS > 1) ? $clog2(SMALL_SLOTS) : 1;
    localparam int MEDIUM_IDX_W = (MEDIUM_SLOTS > 1) ? $clog2(MEDIUM_SLOTS) : 1;
    localparam int LARGE_IDX_W  = (LARGE_SLOTS > 1) ? $clog2(LARGE_SLOTS) : 1;
    localparam int SMALL_TOP_W  = $clog2(SMALL_SLOTS + 1);
    localparam int MEDIUM_TOP_W = $clog2(MEDIUM_SLOTS + 1);
    localparam int LARGE_TOP_W  = $clog2(LARGE_SLOTS + 1);
    localparam int CNT_ADDR_W   = (TOTAL_SLOTS > 1) ? $clog2(TOTAL_SLOTS) : 1;

    localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

    // Register reset values
    localparam logic [LIMIT_W-1:0] SMALL_LIMIT_RST  = 11'd31;
    localparam logic [LIMIT_W-1:0] MEDIUM_LIMIT_RST = 11'd79;
    localparam logic [LIMIT_W-1:0] LARGE_LIMIT_RST  = 11'd1023;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_SMALL_LIMIT  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MEDIUM_LIMIT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_LARGE_LIMIT  = 2'd2;

    // Request modes
    localparam logic [MODE_W-1:0] MODE_ALLOC   = 2'd0;
    localparam logic [MODE_W-1:0] MODE_RETAIN  = 2'd1;
    localparam logic [MODE_W-1:0] MODE_RELEASE = 2'd2;

    // Result status codes
    localparam logic [STATUS_W-1:0] ST_OK        = 3'd0;
    localparam logic [STATUS_W-1:0] ST_TOO_LONG  = 3'd1;
    localparam logic [STATUS_W-1:0] ST_NO_BUF    = 3'd2;
    localparam logic [STATUS_W-1:0] ST_BAD_SLOT  = 3'd3;
    localparam logic [STATUS_W-1:0] ST_SATURATED = 3'd4;

    // Size classes
    localparam logic [CLASS_W-1:0] CLS_SMALL  = 2'd0;
    localparam logic [CLASS_W-1:0] CLS_MEDIUM = 2'd1;
    localparam logic [CLASS_W-1:0] CLS_LARGE  = 2'd2;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DECODE,
        S_POP,
        S_POP_RD,
        S_POP_CHK,
        S_SLOT_CHK
    } state_t;

    typedef struct packed {
        logic latch_in;
        logic set_class;
        logic next_class;
        logic pop;
        logic cnt_rd_pop;
        logic cnt_rd_slot;
        logic res_too_long;
        logic res_no_buf;
        logic res_bad;
        logic commit_alloc;
        logic commit_slot;
    } cmd_t;

    typedef struct packed {
        logic is_alloc;
        logic too_long;
        logic slot_bad;
        logic top_zero;
        logic class_last;
        logic pop_ok;
        logic out_free;
    } sts_t;

    function automatic logic [CLASS_W-1:0] slot_class(input logic [SLOT_W-1:0] s);
        logic [CLASS_W-1:0] c;
        if (int'(s) < SMALL_SLOTS)
            c = CLS_SMALL;
        else if (int'(s) < SMALL_SLOTS + MEDIUM_SLOTS)
            c = CLS_MEDIUM;
        else
            c = CLS_LARGE;
        return c;
    endfunction

endpackage

// ===== sv/scbp_req_if.sv =====
interface scbp_req_if;
    import scbp_pkg::*;

    logic              valid;
    logic              ready;
    logic [MODE_W-1:0] mode;
    logic [LEN_W-1:0]  length;
    logic [SLOT_W-1:0] slot;

    modport source (output valid, mode, length, slot, input ready);
    modport sink   (input valid, mode, length, slot, output ready);
endinterface

// ===== sv/scbp_rsp_if.sv =====
interface scbp_rsp_if;
    import scbp_pkg::*;

    logic                  valid;
    logic                  ready;
    logic [SLOT_W-1:0]     slot_out;
    logic [STATUS_W-1:0]   status;
    logic [CLASS_W-1:0]    size_class;
    logic                  freed;
    logic [COUNT_BITS-1:0] count_after;

    modport source (output valid, slot_out, status, size_class, freed, count_after,
                    input ready);
    modport sink   (input valid, slot_out, status, size_class, freed, count_after,
                    output ready);
endinterface

// ===== sv/size_class_buffer_pool_core.sv =====
// Reference-counted buffer pool with small, medium and large slot classes, each
// kept on a LIFO free stack that is full after reset; slots are numbered small
// first, then medium, then large. Requests arrive on req (allocate, retain,
// release) and one result per request leaves on rsp through an output register,
// so the next request is taken while a result still waits. One request is in
// work at a time: retain and release pass through decode and a registered read
// of the count memory; allocate passes through decode, a pop that moves on past
// each empty class, a registered read of the free stack and a registered read
// of the count memory, and returns to the pop for each stale entry discarded.
// A result not yet taken holds the register and stalls the request in work.
// The three length limits are written through cfg_we, cfg_index and cfg_data;
// the user must write them only while the pool is idle, as the block itself
// does not enforce it. No clearing pass is run after reset.
module size_class_buffer_pool_core (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_we,
    input  logic [scbp_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [scbp_pkg::CFG_DATA_W-1:0] cfg_data,
    scbp_req_if.sink                        req,
    scbp_rsp_if.source                      rsp
);
    import scbp_pkg::*;

    cmd_t cmd;
    sts_t sts;

    scbp_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req.valid),
        .req_ready (req.ready),
        .sts       (sts),
        .cmd       (cmd)
    );

    scbp_dp u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .req_mode   (req.mode),
        .req_length (req.length),
        .req_slot   (req.slot),
        .cmd        (cmd),
        .sts        (sts),
        .rsp        (rsp)
    );

endmodule

// ===== sv/scbp_ctrl.sv =====
module scbp_ctrl (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            req_valid,
    output logic            req_ready,
    input  scbp_pkg::sts_t  sts,
    output scbp_pkg::cmd_t  cmd
);
    import scbp_pkg::*;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                    state_next = S_DECODE;
            end
            S_DECODE:
            begin
                if (sts.is_alloc)
                begin
                    if (!sts.too_long)
                        state_next = S_POP;
                    else if (sts.out_free)
                        state_next = S_IDLE;
                end
                else
                begin
                    if (!sts.slot_bad)
                        state_next = S_SLOT_CHK;
                    else if (sts.out_free)
                        state_next = S_IDLE;
                end
            end
            S_POP:
            begin
                if (!sts.top_zero)
                    state_next = S_POP_RD;
                else if (sts.class_last && sts.out_free)
                    state_next = S_IDLE;
            end
            S_POP_RD:
                state_next = S_POP_CHK;
            S_POP_CHK:
            begin
                // a stale entry sends us back for another pop
                if (!sts.pop_ok)
                    state_next = S_POP;
                else if (sts.out_free)
                    state_next = S_IDLE;
            end
            S_SLOT_CHK:
            begin
                if (sts.out_free)
                    state_next = S_IDLE;
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    always_comb
    begin
        cmd       = '0;
        req_ready = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                req_ready    = 1'b1;
                cmd.latch_in = req_valid;
            end
            S_DECODE:
            begin
                if (sts.is_alloc)
                begin
                    cmd.set_class    = !sts.too_long;
                    cmd.res_too_long = sts.too_long && sts.out_free;
                end
                else
                begin
                    cmd.cnt_rd_slot = !sts.slot_bad;
                    cmd.res_bad     = sts.slot_bad && sts.out_free;
                end
            end
            S_POP:
            begin
                cmd.pop        = !sts.top_zero;
                cmd.next_class = sts.top_zero && !sts.class_last;
                cmd.res_no_buf = sts.top_zero && sts.class_last && sts.out_free;
            end
            S_POP_RD:
                cmd.cnt_rd_pop = 1'b1;
            S_POP_CHK:
                cmd.commit_alloc = sts.pop_ok && sts.out_free;
            S_SLOT_CHK:
                cmd.commit_slot = sts.out_free;
            default:
                cmd = '0;
        endcase
    end

    a_accept_decodes: assert property (@(posedge clk) disable iff (!rst_n)
        (req_valid && req_ready) |=> (state_reg == S_DECODE))
        else $error("accepted item not decoded next cycle");

    a_one_result: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0({cmd.res_too_long, cmd.res_no_buf, cmd.res_bad,
                  cmd.commit_alloc, cmd.commit_slot}))
        else $error("more than one result source in a cycle");

    a_pop_reads: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.pop |=> (state_reg == S_POP_RD))
        else $error("stack pop not followed by its read stage");

endmodule

// ===== sv/scbp_dp.sv =====
module scbp_dp (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_we,
    input  logic [scbp_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [scbp_pkg::CFG_DATA_W-1:0] cfg_data,
    input  logic [scbp_pkg::MODE_W-1:0]     req_mode,
    input  logic [scbp_pkg::LEN_W-1:0]      req_length,
    input  logic [scbp_pkg::SLOT_W-1:0]     req_slot,
    input  scbp_pkg::cmd_t                  cmd,
    output scbp_pkg::sts_t                  sts,
    scbp_rsp_if.source                      rsp
);
    import scbp_pkg::*;

    // Latched request
    logic [MODE_W-1:0] mode_reg;
    logic [LEN_W-1:0]  length_reg;
    logic [SLOT_W-1:0] slot_reg;

    logic [LIMIT_W-1:0] small_limit_reg;
    logic [LIMIT_W-1:0] medium_limit_reg;
    logic [LIMIT_W-1:0] large_limit_reg;

    logic [CLASS_W-1:0] cls_reg;
    logic [CLASS_W-1:0] cls_start;
    logic               too_long;

    // Free stacks
    logic [SLOT_W-1:0] small_mem  [0:SMALL_SLOTS-1];
    logic [SLOT_W-1:0] medium_mem [0:MEDIUM_SLOTS-1];
    logic [SLOT_W-1:0] large_mem  [0:LARGE_SLOTS-1];
    logic [SMALL_SLOTS-1:0]  small_vld_reg;
    logic [MEDIUM_SLOTS-1:0] medium_vld_reg;
    logic [LARGE_SLOTS-1:0]  large_vld_reg;

    logic [SMALL_TOP_W-1:0]  small_top_reg,  small_top_next;
    logic [MEDIUM_TOP_W-1:0] medium_top_reg, medium_top_next;
    logic [LARGE_TOP_W-1:0]  large_top_reg,  large_top_next;

    logic [SMALL_IDX_W-1:0]  small_pop_idx,  small_push_idx;
    logic [MEDIUM_IDX_W-1:0] medium_pop_idx, medium_push_idx;
    logic [LARGE_IDX_W-1:0]  large_pop_idx,  large_push_idx;

    logic [SLOT_W-1:0] stk_rd_reg;
    logic              stk_rd_vld_reg;
    logic [SLOT_W-1:0] stk_dflt_reg;
    logic [SLOT_W-1:0] pop_slot;
    logic              pop_in_range;

    logic              top_zero;
    logic [CLASS_W-1:0] push_cls;
    logic              push_room;
    logic              push_do;

    // Reference counts
    logic [COUNT_BITS-1:0] cnt_mem [0:TOTAL_SLOTS-1];
    logic [TOTAL_SLOTS-1:0] cnt_vld_reg;
    logic [COUNT_BITS-1:0] cnt_rd_reg;
    logic                  cnt_rd_vld_reg;
    logic [COUNT_BITS-1:0] cnt_val;
    logic [COUNT_BITS-1:0] cnt_inc;
    logic [COUNT_BITS-1:0] cnt_dec;
    logic [CNT_ADDR_W-1:0] cnt_rd_addr;
    logic [CNT_ADDR_W-1:0] cnt_wr_addr;
    logic [COUNT_BITS-1:0] cnt_wr_data;
    logic                  cnt_we;
    logic                  slot_live;
    logic                  sat;
    logic                  is_retain;
    logic                  is_release;

    // Result register
    logic                  res_load;
    logic                  out_free;
    logic                  rsp_valid_reg, rsp_valid_next;
    logic [SLOT_W-1:0]     slot_out_reg,  slot_out_next;
    logic [STATUS_W-1:0]   status_reg,    status_next;
    logic [CLASS_W-1:0]    class_reg,     class_next;
    logic                  freed_reg,     freed_next;
    logic [COUNT_BITS-1:0] count_reg,     count_next;

    always_ff @(posedge clk)
    begin
        if (cmd.latch_in)
        begin
            mode_reg   <= req_mode;
            length_reg <= req_length;
            slot_reg   <= req_slot;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            small_limit_reg  <= SMALL_LIMIT_RST;
            medium_limit_reg <= MEDIUM_LIMIT_RST;
            large_limit_reg  <= LARGE_LIMIT_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_SMALL_LIMIT:  small_limit_reg  <= cfg_data;
                CFG_MEDIUM_LIMIT: medium_limit_reg <= cfg_data;
                CFG_LARGE_LIMIT:  large_limit_reg  <= cfg_data;
                default: ;
            endcase
        end
    end

    // Pick the first class whose limit the length stays below
    always_comb
    begin
        too_long  = 1'b0;
        cls_start = CLS_SMALL;
        if (length_reg < small_limit_reg)
            cls_start = CLS_SMALL;
        else if (length_reg < medium_limit_reg)
            cls_start = CLS_MEDIUM;
        else if (length_reg < large_limit_reg)
            cls_start = CLS_LARGE;
        else
            too_long = 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cls_reg <= CLS_SMALL;
        else if (cmd.set_class)
            cls_reg <= cls_start;
        else if (cmd.next_class)
            cls_reg <= cls_reg + CLASS_W'(1);
    end

    assign small_pop_idx   = SMALL_IDX_W'(small_top_reg - SMALL_TOP_W'(1));
    assign medium_pop_idx  = MEDIUM_IDX_W'(medium_top_reg - MEDIUM_TOP_W'(1));
    assign large_pop_idx   = LARGE_IDX_W'(large_top_reg - LARGE_TOP_W'(1));
    assign small_push_idx  = small_top_reg[SMALL_IDX_W-1:0];
    assign medium_push_idx = medium_top_reg[MEDIUM_IDX_W-1:0];
    assign large_push_idx  = large_top_reg[LARGE_IDX_W-1:0];

    always_comb
    begin
        case (cls_reg)
            CLS_SMALL:  top_zero = (small_top_reg == '0);
            CLS_MEDIUM: top_zero = (medium_top_reg == '0);
            default:    top_zero = (large_top_reg == '0);
        endcase
    end

    assign is_retain  = (mode_reg == MODE_RETAIN);
    assign is_release = (mode_reg == MODE_RELEASE);

    assign cnt_val   = cnt_rd_vld_reg ? cnt_rd_reg : '0;
    assign slot_live = (cnt_val != '0);
    assign sat       = (cnt_val == COUNT_MAX);
    assign cnt_inc   = cnt_val + COUNT_BITS'(1);
    assign cnt_dec   = cnt_val - COUNT_BITS'(1);

    assign push_cls = slot_class(slot_reg);

    always_comb
    begin
        case (push_cls)
            CLS_SMALL:  push_room = (small_top_reg < SMALL_TOP_W'(SMALL_SLOTS));
            CLS_MEDIUM: push_room = (medium_top_reg < MEDIUM_TOP_W'(MEDIUM_SLOTS));
            default:    push_room = (large_top_reg < LARGE_TOP_W'(LARGE_SLOTS));
        endcase
    end

    // Return the slot when this release drops its last reference
    assign push_do = cmd.commit_slot && is_release && (cnt_val == COUNT_BITS'(1)) && push_room;

    always_comb
    begin
        small_top_next  = small_top_reg;
        medium_top_next = medium_top_reg;
        large_top_next  = large_top_reg;
        if (cmd.pop && cls_reg == CLS_SMALL)
            small_top_next = small_top_reg - SMALL_TOP_W'(1);
        else if (push_do && push_cls == CLS_SMALL)
            small_top_next = small_top_reg + SMALL_TOP_W'(1);
        if (cmd.pop && cls_reg == CLS_MEDIUM)
            medium_top_next = medium_top_reg - MEDIUM_TOP_W'(1);
        else if (push_do && push_cls == CLS_MEDIUM)
            medium_top_next = medium_top_reg + MEDIUM_TOP_W'(1);
        if (cmd.pop && cls_reg == CLS_LARGE)
            large_top_next = large_top_reg - LARGE_TOP_W'(1);
        else if (push_do && push_cls == CLS_LARGE)
            large_top_next = large_top_reg + LARGE_TOP_W'(1);
    end

    // An entry never written since reset still holds its class's slot in order
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            small_top_reg  <= SMALL_TOP_W'(SMALL_SLOTS);
            medium_top_reg <= MEDIUM_TOP_W'(MEDIUM_SLOTS);
            large_top_reg  <= LARGE_TOP_W'(LARGE_SLOTS);
            small_vld_reg  <= '0;
            medium_vld_reg <= '0;
            large_vld_reg  <= '0;
        end
        else
        begin
            small_top_reg  <= small_top_next;
            medium_top_reg <= medium_top_next;
            large_top_reg  <= large_top_next;
            if (push_do && push_cls == CLS_SMALL)
                small_vld_reg[small_push_idx] <= 1'b1;
            if (push_do && push_cls == CLS_MEDIUM)
                medium_vld_reg[medium_push_idx] <= 1'b1;
            if (push_do && push_cls == CLS_LARGE)
                large_vld_reg[large_push_idx] <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push_do && push_cls == CLS_SMALL)
            small_mem[small_push_idx] <= slot_reg;
        if (push_do && push_cls == CLS_MEDIUM)
            medium_mem[medium_push_idx] <= slot_reg;
        if (push_do && push_cls == CLS_LARGE)
            large_mem[large_push_idx] <= slot_reg;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.pop)
        begin
            case (cls_reg)
                CLS_SMALL:
                begin
                    stk_rd_reg     <= small_mem[small_pop_idx];
                    stk_rd_vld_reg <= small_vld_reg[small_pop_idx];
                    stk_dflt_reg   <= SLOT_W'(SMALL_BASE) + SLOT_W'(small_pop_idx);
                end
                CLS_MEDIUM:
                begin
                    stk_rd_reg     <= medium_mem[medium_pop_idx];
                    stk_rd_vld_reg <= medium_vld_reg[medium_pop_idx];
                    stk_dflt_reg   <= SLOT_W'(MEDIUM_BASE) + SLOT_W'(medium_pop_idx);
                end
                default:
                begin
                    stk_rd_reg     <= large_mem[large_pop_idx];
                    stk_rd_vld_reg <= large_vld_reg[large_pop_idx];
                    stk_dflt_reg   <= SLOT_W'(LARGE_BASE) + SLOT_W'(large_pop_idx);
                end
            endcase
        end
    end

    assign pop_slot     = stk_rd_vld_reg ? stk_rd_reg : stk_dflt_reg;
    assign pop_in_range = (int'(pop_slot) < TOTAL_SLOTS);

    assign cnt_rd_addr = cmd.cnt_rd_pop ? pop_slot[CNT_ADDR_W-1:0] : slot_reg[CNT_ADDR_W-1:0];
    assign cnt_wr_addr = cmd.commit_alloc ? pop_slot[CNT_ADDR_W-1:0]
                                          : slot_reg[CNT_ADDR_W-1:0];
    assign cnt_wr_data = cmd.commit_alloc ? COUNT_BITS'(1) : (is_retain ? cnt_inc : cnt_dec);
    assign cnt_we      = cmd.commit_alloc ||
                         (cmd.commit_slot && slot_live && !(is_retain && sat));

    always_ff @(posedge clk)
    begin
        if (cmd.cnt_rd_pop || cmd.cnt_rd_slot)
        begin
            cnt_rd_reg     <= cnt_mem[cnt_rd_addr];
            cnt_rd_vld_reg <= cnt_vld_reg[cnt_rd_addr];
        end
        if (cnt_we)
            cnt_mem[cnt_wr_addr] <= cnt_wr_data;
    end

    // A count never written reads as zero
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cnt_vld_reg <= '0;
        else if (cnt_we)
            cnt_vld_reg[cnt_wr_addr] <= 1'b1;
    end

    assign out_free = !rsp_valid_reg || rsp.ready;
    assign res_load = cmd.res_too_long || cmd.res_no_buf || cmd.res_bad ||
                      cmd.commit_alloc || cmd.commit_slot;

    always_comb
    begin
        slot_out_next = '0;
        status_next   = ST_BAD_SLOT;
        class_next    = CLS_SMALL;
        freed_next    = 1'b0;
        count_next    = '0;
        if (cmd.res_too_long)
            status_next = ST_TOO_LONG;
        else if (cmd.res_no_buf)
            status_next = ST_NO_BUF;
        else if (cmd.commit_alloc)
        begin
            slot_out_next = pop_slot;
            status_next   = ST_OK;
            class_next    = slot_class(pop_slot);
            count_next    = COUNT_BITS'(1);
        end
        else if (cmd.commit_slot)
        begin
            slot_out_next = slot_reg;
            class_next    = push_cls;
            if (!slot_live)
                status_next = ST_BAD_SLOT;
            else if (is_retain && sat)
            begin
                status_next = ST_SATURATED;
                count_next  = cnt_val;
            end
            else if (is_retain)
            begin
                status_next = ST_OK;
                count_next  = cnt_inc;
            end
            else
            begin
                status_next = ST_OK;
                count_next  = cnt_dec;
                freed_next  = push_do;
            end
        end
    end

    assign rsp_valid_next = res_load || (rsp_valid_reg && !rsp.ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            rsp_valid_reg <= 1'b0;
        else
            rsp_valid_reg <= rsp_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (res_load)
        begin
            slot_out_reg <= slot_out_next;
            status_reg   <= status_next;
            class_reg    <= class_next;
            freed_reg    <= freed_next;
            count_reg    <= count_next;
        end
    end

    assign rsp.valid       = rsp_valid_reg;
    assign rsp.slot_out    = slot_out_reg;
    assign rsp.status      = status_reg;
    assign rsp.size_class  = class_reg;
    assign rsp.freed       = freed_reg;
    assign rsp.count_after = count_reg;

    assign sts.is_alloc   = (mode_reg == MODE_ALLOC);
    assign sts.too_long   = too_long;
    assign sts.slot_bad   = !(is_retain || is_release) || (int'(slot_reg) >= TOTAL_SLOTS);
    assign sts.top_zero   = top_zero;
    assign sts.class_last = (cls_reg == CLS_LARGE);
    assign sts.pop_ok     = pop_in_range && !slot_live;
    assign sts.out_free   = out_free;

    a_tops_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        (int'(small_top_reg) <= SMALL_SLOTS) && (int'(medium_top_reg) <= MEDIUM_SLOTS) &&
        (int'(large_top_reg) <= LARGE_SLOTS))
        else $error("free stack fill count beyond its depth");

    a_load_when_free: assert property (@(posedge clk) disable iff (!rst_n)
        res_load |-> out_free)
        else $error("result loaded over an item not yet taken");

    a_alloc_gives_one: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.commit_alloc |=> (rsp_valid_reg && status_reg == ST_OK &&
                              count_reg == COUNT_BITS'(1)))
        else $error("allocation result not shown with count one");

endmodule
